@@ hdl/ustcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ustcd_pkg
// Shared types, constants and calendar helpers for the seconds-to-date block.
// ----------------------------------------------------------------------------
package ustcd_pkg;

    localparam int TS_W  = 32;  // input timestamp width
    localparam int DAY_W = 16;  // day number width (at most 49710)
    localparam int TOD_W = 17;  // second of the day, below 86400
    localparam int SOH_W = 12;  // second of the hour, below 3600

    // 86400 = 2^7 * 675, 3600 = 2^4 * 225 and 60 = 2^2 * 15. Drop the power of
    // two by a shift, then divide by the odd part with a reciprocal multiply
    // that is exact over the whole operand range of each stage.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [9:0]  DAY_ODD    = 10'd675;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [7:0]  HOUR_ODD   = 8'd225;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // ceil(2^14 / 15)
    localparam logic [3:0]  MIN_ODD    = 4'd15;

    localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
    localparam logic [11:0] CENTURY_NON_LEAP = 12'd2100;
    localparam logic [11:0] YEAR_MAX         = 12'd2106;
    localparam logic [3:0]  LAST_MONTH       = 4'd11;
    localparam logic [2:0]  EPOCH_WEEKDAY    = 3'd4;  // 1970-01-01 was a Thursday

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_QUO,
        ST_DAY_REM,
        ST_HOUR_QUO,
        ST_HOUR_REM,
        ST_MIN_QUO,
        ST_SAVE_TIME,
        ST_YEARS,
        ST_MONTHS,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_TS,
        DP_DAY_QUO,
        DP_DAY_REM,
        DP_HOUR_QUO,
        DP_HOUR_REM,
        DP_MIN_QUO,
        DP_SAVE_TIME,
        DP_YEAR_STEP,
        DP_MONTH_STEP,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic year_done;   // remaining days fit inside the current year
        logic month_done;  // remaining days fit inside the current month, or it is the last month
    } dp_status_t;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [11:0] year_val;
        logic [3:0]  month_index;
        logic [4:0]  day_index;
        logic [4:0]  hours_val;
        logic [5:0]  minutes_val;
        logic [5:0]  seconds_val;
    } result_t;

    // Within 1970..2106 the only century year that is not a leap year is 2100.
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != CENTURY_NON_LEAP);
    endfunction

    function automatic logic [8:0] year_len(input logic [11:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Residue mod 7 of a small sum (at most 41).
    function automatic logic [2:0] mod7(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        if (r >= 6'd35)
            r = r - 6'd35;
        else if (r >= 6'd28)
            r = r - 6'd28;
        else if (r >= 6'd21)
            r = r - 6'd21;
        else if (r >= 6'd14)
            r = r - 6'd14;
        else if (r >= 6'd7)
            r = r - 6'd7;
        if (r >= 6'd7)
            r = r - 6'd7;
        return r[2:0];
    endfunction

endpackage
`default_nettype wire

@@ hdl/ustcd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ustcd_datapath
// Reciprocal-multiply split of the count, year and month walk, result register.
// ----------------------------------------------------------------------------
module ustcd_datapath (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  [31:0]              ts,
    input  ustcd_pkg::dp_ctrl_t      ctrl,
    output ustcd_pkg::dp_status_t    status,
    output ustcd_pkg::result_t       result
);
    import ustcd_pkg::*;

    logic [TS_W-1:0]  ts_reg;
    logic [DAY_W-1:0] days_reg;
    logic [TOD_W-1:0] tod_reg;
    logic [SOH_W-1:0] soh_reg;
    logic [11:0]      year_reg;
    logic [3:0]       mon_reg;
    logic [2:0]       wday_reg;
    logic [4:0]       hours_reg;
    logic [5:0]       minutes_reg;
    logic [5:0]       seconds_reg;
    result_t          res_reg;

    logic [50:0]      day_prod;
    logic [25:0]      day_back;
    logic [24:0]      day_rem;
    logic [26:0]      hour_prod;
    logic [12:0]      hour_back;
    logic [12:0]      hour_rem;
    logic [20:0]      min_prod;
    logic [9:0]       min_back;
    logic [9:0]       min_rem;
    logic             leap;
    logic [8:0]       ylen;
    logic [4:0]       mlen;
    logic [4:0]       mlen_excess;

    // day number = (ts >> 7) / 675; multiply back for the remainder
    assign day_prod  = ts_reg[31:7] * DAY_RECIP;
    assign day_back  = days_reg * DAY_ODD;
    assign day_rem   = ts_reg[31:7] - day_back[24:0];

    // hour = (second of day >> 4) / 225
    assign hour_prod = tod_reg[16:4] * HOUR_RECIP;
    assign hour_back = hours_reg * HOUR_ODD;
    assign hour_rem  = tod_reg[16:4] - hour_back;

    // minute = (second of hour >> 2) / 15
    assign min_prod  = soh_reg[11:2] * MIN_RECIP;
    assign min_back  = minutes_reg * MIN_ODD;
    assign min_rem   = soh_reg[11:2] - min_back;

    assign leap        = is_leap(year_reg);
    assign ylen        = year_len(year_reg);
    assign mlen        = month_len(mon_reg, leap);
    assign mlen_excess = mlen - 5'd28;  // month length mod 7

    assign status.year_done  = (days_reg < {{(DAY_W-9){1'b0}}, ylen});
    assign status.month_done = (mon_reg == LAST_MONTH) ||
                               (days_reg < {{(DAY_W-5){1'b0}}, mlen});

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            DP_LOAD_TS:
            begin
                ts_reg <= ts;
            end
            DP_DAY_QUO:
            begin
                days_reg <= day_prod[50:35];
            end
            DP_DAY_REM:
            begin
                // put the shifted-out low bits back under the odd remainder
                tod_reg <= {day_rem[9:0], ts_reg[6:0]};
            end
            DP_HOUR_QUO:
            begin
                hours_reg <= hour_prod[25:21];
            end
            DP_HOUR_REM:
            begin
                soh_reg <= {hour_rem[7:0], tod_reg[3:0]};
            end
            DP_MIN_QUO:
            begin
                minutes_reg <= min_prod[19:14];
            end
            DP_SAVE_TIME:
            begin
                seconds_reg <= {min_rem[3:0], soh_reg[1:0]};
                year_reg    <= EPOCH_YEAR;
                mon_reg     <= '0;
                wday_reg    <= EPOCH_WEEKDAY;
            end
            DP_YEAR_STEP:
            begin
                days_reg <= days_reg - {{(DAY_W-9){1'b0}}, ylen};
                year_reg <= year_reg + 12'd1;
                wday_reg <= mod7({3'b000, wday_reg} + (leap ? 6'd2 : 6'd1));
            end
            DP_MONTH_STEP:
            begin
                days_reg <= days_reg - {{(DAY_W-5){1'b0}}, mlen};
                mon_reg  <= mon_reg + 4'd1;
                wday_reg <= mod7({3'b000, wday_reg} + {3'b000, mlen_excess[2:0]});
            end
            DP_FINISH:
            begin
                res_reg.seconds_val <= seconds_reg;
                res_reg.minutes_val <= minutes_reg;
                res_reg.hours_val   <= hours_reg;
                res_reg.day_index   <= days_reg[4:0];
                res_reg.month_index <= mon_reg;
                res_reg.year_val    <= year_reg;
                res_reg.weekday     <= mod7({3'b000, wday_reg} + {1'b0, days_reg[4:0]});
            end
            default:
            begin
            end
        endcase
    end

    assign result = res_reg;

    a_day_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == DP_DAY_REM) |-> (day_rem < {15'd0, DAY_ODD}))
        else $error("day remainder out of range");

    a_hours_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == DP_HOUR_QUO) |-> (hour_prod[26:21] < 6'd24))
        else $error("hour quotient out of range");

    a_minutes_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == DP_MIN_QUO) |-> (min_prod[20:14] < 7'd60))
        else $error("minute quotient out of range");

    a_days_fit_month: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == DP_FINISH) |-> (days_reg < {{(DAY_W-5){1'b0}}, mlen}))
        else $error("remaining days exceed the month at finish");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == DP_YEAR_STEP) |-> (year_reg < YEAR_MAX))
        else $error("year walk ran past the last reachable year");

endmodule
`default_nettype wire

@@ hdl/ustcd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ustcd_ctrl
// Sequencer: day, hour and minute split, year and month walk, output handshake.
// ----------------------------------------------------------------------------
module ustcd_ctrl (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    input  ustcd_pkg::dp_status_t    status,
    output ustcd_pkg::dp_ctrl_t      ctrl
);
    import ustcd_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl.op        = DP_NOP;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.op    = DP_LOAD_TS;
                    state_next = ST_DAY_QUO;
                end
            end
            ST_DAY_QUO:
            begin
                ctrl.op    = DP_DAY_QUO;
                state_next = ST_DAY_REM;
            end
            ST_DAY_REM:
            begin
                ctrl.op    = DP_DAY_REM;
                state_next = ST_HOUR_QUO;
            end
            ST_HOUR_QUO:
            begin
                ctrl.op    = DP_HOUR_QUO;
                state_next = ST_HOUR_REM;
            end
            ST_HOUR_REM:
            begin
                ctrl.op    = DP_HOUR_REM;
                state_next = ST_MIN_QUO;
            end
            ST_MIN_QUO:
            begin
                ctrl.op    = DP_MIN_QUO;
                state_next = ST_SAVE_TIME;
            end
            ST_SAVE_TIME:
            begin
                ctrl.op    = DP_SAVE_TIME;
                state_next = ST_YEARS;
            end
            ST_YEARS:
            begin
                if (status.year_done)
                    state_next = ST_MONTHS;
                else
                    ctrl.op = DP_YEAR_STEP;
            end
            ST_MONTHS:
            begin
                if (status.month_done)
                    state_next = ST_FINISH;
                else
                    ctrl.op = DP_MONTH_STEP;
            end
            ST_FINISH:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || m_tready)
                begin
                    ctrl.op        = DP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == DP_FINISH) |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while a word waits");

    a_start_split: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_DAY_QUO))
        else $error("accepted word did not start the day split");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && state_reg != ST_FINISH) |=> !m_tvalid)
        else $error("output valid stayed high after a drain with no new result");

endmodule
`default_nettype wire

@@ hdl/unix_seconds_to_calendar_date.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date
// Converts seconds since 1970-01-01 00:00:00 UTC into the broken-down date.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_t*) takes one 32-bit word: unsigned seconds since the
//   epoch. Master channel (m_t*) returns one word per input: second, minute,
//   hour, zero-based day and month, full year and weekday (0 is Sunday).
//   One word is in work at a time; s_tready is high only while idle.
//   After a word is accepted, five steps of reciprocal multiply and
//   multiply-back split the count by day, hour and minute; one step takes
//   the seconds and seeds the walk; then the year walk strips whole years
//   since 1970 (0..136), the month walk strips months (0..11) and a last
//   step captures the result. The last reachable date is in February 2106.
//   A new word can be taken in the cycle after the previous result is
//   posted.
//   The result sits in its own output register, so the next word is
//   accepted and worked on while m_tready is low; only the final capture
//   waits until the held word has been taken.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//   any pending output word.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] unix_seconds
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // [5:0] seconds_val, [11:6] minutes_val,
                                   // [16:12] hours_val, [21:17] day_index,
                                   // [25:22] month_index, [37:26] year_val,
                                   // [40:38] weekday, [47:41] zero
);
    import ustcd_pkg::*;

    dp_ctrl_t   ctrl;
    dp_status_t status;
    result_t    result;

    // sequencer: steps through the time split and the calendar walk
    ustcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // datapath: reciprocal multipliers, year and month subtractors, result register
    ustcd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ts     (s_tdata),
        .ctrl   (ctrl),
        .status (status),
        .result (result)
    );

    // pack the result word, seconds in the lowest bits
    assign m_tdata = {7'b0000000,
                      result.weekday,
                      result.year_val,
                      result.month_index,
                      result.day_index,
                      result.hours_val,
                      result.minutes_val,
                      result.seconds_val};

endmodule
`default_nettype wire

@@ tb/unix_seconds_to_calendar_date_tb.sv @@
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date_tb
// Self-checking bench for the seconds-to-date converter. A short table of
// directed timestamps (epoch, top of range, day, month, year and century
// edges) is followed by about a thousand random ones. Each expected date is
// typed in by hand or comes from a calendar predictor held here. Every output
// word is compared field by field with the oldest outstanding date.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date_tb;

    import ustcd_pkg::*;

    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned RANDOM_WORDS = 1050;
    localparam int unsigned HOLDOFF_AT   = 300;   // results taken before the long stall
    localparam int unsigned HOLDOFF_LEN  = 1500;  // cycles of the long stall
    localparam int unsigned DRAIN_CYCLES = 250;   // longer than the slowest conversion

    // One directed row: timestamp, whether the date below is typed in by
    // hand, and that date (fields from weekday down to seconds).
    typedef struct packed {
        logic [31:0] stamp;
        logic        fixed;
        result_t     date;
    } date_case_t;

    localparam result_t NO_DATE = '0;

    //                               weekday year    mon   day   hour  min   sec
    localparam date_case_t DATE_CASES [0:23] = '{
        {32'd0,          1'b1, {3'd4, 12'd1970, 4'd0, 5'd0, 5'd0,  6'd0,  6'd0}},
        {32'd59,         1'b1, {3'd4, 12'd1970, 4'd0, 5'd0, 5'd0,  6'd0,  6'd59}},
        {32'd86399,      1'b1, {3'd4, 12'd1970, 4'd0, 5'd0, 5'd23, 6'd59, 6'd59}},
        {32'd86400,      1'b1, {3'd5, 12'd1970, 4'd0, 5'd1, 5'd0,  6'd0,  6'd0}},
        {32'd4294967295, 1'b1, {3'd0, 12'd2106, 4'd1, 5'd6, 5'd6,  6'd28, 6'd15}},
        {32'd60,         1'b0, NO_DATE},
        {32'd3599,       1'b0, NO_DATE},
        {32'd3600,       1'b0, NO_DATE},
        {32'd28857600,   1'b0, NO_DATE},   // first of December 1970
        {32'd31535999,   1'b0, NO_DATE},   // last second of 1970
        {32'd31536000,   1'b0, NO_DATE},
        {32'd68169600,   1'b0, NO_DATE},   // leap day 1972
        {32'd68255999,   1'b0, NO_DATE},
        {32'd946684799,  1'b0, NO_DATE},
        {32'd951782400,  1'b0, NO_DATE},   // leap day of a 400-year
        {32'd2147483647, 1'b0, NO_DATE},
        {32'd2147483648, 1'b0, NO_DATE},
        {32'd4102444799, 1'b0, NO_DATE},
        {32'd4107456000, 1'b0, NO_DATE},   // 28 Feb 2100, century without leap day
        {32'd4107542399, 1'b0, NO_DATE},
        {32'd4107542400, 1'b0, NO_DATE},   // must roll straight to 1 March
        {32'hAAAAAAAA,   1'b0, NO_DATE},
        {32'h55555555,   1'b0, NO_DATE},
        {32'hFFFEAE80,   1'b0, NO_DATE}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] unix_seconds
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [5:0] seconds_val, [11:6] minutes_val,
                                  // [16:12] hours_val, [21:17] day_index,
                                  // [25:22] month_index, [37:26] year_val,
                                  // [40:38] weekday, [47:41] zero

    result_t     pending_dates [$];
    int unsigned dates_taken  = 0;
    int unsigned fault_count  = 0;

    unix_seconds_to_calendar_date uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------

    // Full Gregorian rule, so 2100 drops its leap day while 2000 keeps it.
    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
        int unsigned lengths [12];
        lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mon == 1 && leap_year(yr))
            return 29;
        return lengths[mon];
    endfunction

    function automatic result_t calendar_of(input logic [31:0] stamp);
        result_t     date;
        int unsigned secs;
        int unsigned tod;
        int unsigned day_num;
        int unsigned yr;
        int unsigned mon;
        secs    = stamp;
        tod     = secs % DAY_SECS;
        day_num = secs / DAY_SECS;
        // The epoch fell on a Thursday.
        date.weekday     = 3'((day_num + 4) % 7);
        date.seconds_val = 6'(tod % 60);
        date.minutes_val = 6'((tod / 60) % 60);
        date.hours_val   = 5'(tod / 3600);
        // Strip whole years, then whole months; what is left is the day.
        yr = 1970;
        while (day_num >= (leap_year(yr) ? 366 : 365))
        begin
            day_num -= leap_year(yr) ? 366 : 365;
            yr++;
        end
        mon = 0;
        while (mon < 11 && day_num >= month_length(mon, yr))
        begin
            day_num -= month_length(mon, yr);
            mon++;
        end
        date.day_index   = 5'(day_num);
        date.month_index = 4'(mon);
        date.year_val    = 12'(yr);
        return date;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Half the words span the whole range; the rest lean on day, year and
    // century edges and on early years, where the calendar walk is short.
    function automatic logic [31:0] pick_stamp();
        longint unsigned day_num;
        int unsigned     yr;
        int unsigned     kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return $urandom();
        if (kind < 7)
        begin
            day_num = $urandom_range(0, 49709);
            case ($urandom_range(0, 2))
                0:       return 32'(day_num * DAY_SECS);
                1:       return 32'(day_num * DAY_SECS + DAY_SECS - 1);
                default: return 32'(day_num * DAY_SECS + $urandom_range(0, DAY_SECS - 1));
            endcase
        end
        if (kind == 7)
        begin
            // Last or first second of a random year.
            yr      = $urandom_range(1971, 2106);
            day_num = 0;
            for (int unsigned y = 1970; y < yr; y++)
                day_num += leap_year(y) ? 366 : 365;
            return 32'(day_num * DAY_SECS - 1 + $urandom_range(0, 1));
        end
        if (kind == 8)
            return 32'(64'd4107456000 - DAY_SECS + $urandom_range(0, 3 * DAY_SECS));
        return $urandom_range(0, 200_000_000);
    endfunction

    // Offer one word and hold it until taken; queue its date on acceptance.
    task automatic offer_word(input logic [31:0] stamp, input result_t date);
        s_tdata  <= stamp;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_dates.push_back(date);
    endtask

    initial
    begin : stimulus
        int unsigned left;
        int unsigned burst;
        int unsigned gap;
        logic [31:0] stamp;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back.
        foreach (DATE_CASES[i])
            offer_word(DATE_CASES[i].stamp,
                       DATE_CASES[i].fixed ? DATE_CASES[i].date
                                           : calendar_of(DATE_CASES[i].stamp));

        // Random words in bursts; gaps run from none to longer than one
        // conversion, so new words land on every phase of the work.
        left = RANDOM_WORDS;
        while (left > 0)
        begin
            burst = $urandom_range(1, 8);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                stamp = pick_stamp();
                offer_word(stamp, calendar_of(stamp));
            end
            left -= burst;
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 20);
                default: gap = $urandom_range(21, 240);
            endcase
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // Drain, then watch a while longer for stray words.
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("** unix_seconds_to_calendar_date: PASSED **");
        else
            $display("** unix_seconds_to_calendar_date: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus one long hold-off that backs
    // the block up until it drops s_tready.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned stall_mode;
        int unsigned mode_left;
        bit          held_off;
        stall_mode = 0;
        mode_left  = 0;
        held_off   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && dates_taken >= HOLDOFF_AT)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 400);
                end
                mode_left--;
                case (stall_mode)
                    0:       m_tready <= 1'b1;                       // no stalls
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------
    function automatic int unsigned field_fault(input string name, input int unsigned want,
                                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            dates_taken++;
            got = m_tdata[40:0];
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual %h", $time, m_tdata);
                fault_count++;
            end
            else
            begin
                want = pending_dates.pop_front();
                fault_count += field_fault("seconds_val", want.seconds_val, got.seconds_val);
                fault_count += field_fault("minutes_val", want.minutes_val, got.minutes_val);
                fault_count += field_fault("hours_val",   want.hours_val,   got.hours_val);
                fault_count += field_fault("day_index",   want.day_index,   got.day_index);
                fault_count += field_fault("month_index", want.month_index, got.month_index);
                fault_count += field_fault("year_val",    want.year_val,    got.year_val);
                fault_count += field_fault("weekday",     want.weekday,     got.weekday);
                fault_count += field_fault("tdata pad",   0,                m_tdata[47:41]);
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin : watchdog
        #12_000_000;
        $display("** unix_seconds_to_calendar_date: FAILED **");
        $finish;
    end

endmodule
